[rtl/odestep_pkg.sv]
`timescale 1ns / 1ps
package odestep_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int STEP_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int PC_W          = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD     = 3'd4;

    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 16'd1;

    // integration methods
    localparam logic [1:0] METH_EULER = 2'd0;
    localparam logic [1:0] METH_RK2   = 2'd1;
    localparam logic [1:0] METH_RK4   = 2'd2;

    // datapath operations
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_HALF  = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_SIXTH = 2'd3;

    // datapath register codes (operand sources and destinations)
    localparam logic [3:0] SRC_X  = 4'd0;
    localparam logic [3:0] SRC_Y  = 4'd1;
    localparam logic [3:0] SRC_H  = 4'd2;
    localparam logic [3:0] SRC_K1 = 4'd3;
    localparam logic [3:0] SRC_K2 = 4'd4;
    localparam logic [3:0] SRC_K3 = 4'd5;
    localparam logic [3:0] SRC_T  = 4'd6;
    localparam logic [3:0] SRC_XM = 4'd7;
    localparam logic [3:0] SRC_U  = 4'd8;
    localparam logic [3:0] SRC_S  = 4'd9;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [3:0] dst;
        logic       fin;
    } uop_t;

    typedef struct packed {
        logic restart;
        logic clear_sat;
        logic issue;
        uop_t uop;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_stat_t;

    function automatic uop_t mk(input logic [1:0] op, input logic [3:0] a,
                                input logic [3:0] b, input logic [3:0] d,
                                input logic fin);
        uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        u.fin   = fin;
        return u;
    endfunction

    function automatic uop_t prog_euler(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = mk(OP_MUL, SRC_X, SRC_X,  SRC_T,  1'b0);
            5'd1:    u = mk(OP_ADD, SRC_T, SRC_Y,  SRC_K1, 1'b0);
            5'd2:    u = mk(OP_MUL, SRC_H, SRC_K1, SRC_T,  1'b0);
            5'd3:    u = mk(OP_ADD, SRC_Y, SRC_T,  SRC_Y,  1'b0);
            default: u = mk(OP_ADD, SRC_X, SRC_H,  SRC_X,  1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t prog_rk2(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = mk(OP_MUL,  SRC_X,  SRC_X,  SRC_T,  1'b0);
            5'd1:    u = mk(OP_ADD,  SRC_T,  SRC_Y,  SRC_K1, 1'b0);
            5'd2:    u = mk(OP_ADD,  SRC_X,  SRC_H,  SRC_XM, 1'b0);
            5'd3:    u = mk(OP_MUL,  SRC_H,  SRC_K1, SRC_T,  1'b0);
            5'd4:    u = mk(OP_ADD,  SRC_Y,  SRC_T,  SRC_T,  1'b0);
            5'd5:    u = mk(OP_MUL,  SRC_XM, SRC_XM, SRC_K2, 1'b0);
            5'd6:    u = mk(OP_ADD,  SRC_K2, SRC_T,  SRC_K2, 1'b0);
            5'd7:    u = mk(OP_ADD,  SRC_K1, SRC_K2, SRC_S,  1'b0);
            5'd8:    u = mk(OP_HALF, SRC_S,  SRC_S,  SRC_S,  1'b0);
            5'd9:    u = mk(OP_MUL,  SRC_H,  SRC_S,  SRC_T,  1'b0);
            5'd10:   u = mk(OP_ADD,  SRC_Y,  SRC_T,  SRC_Y,  1'b0);
            default: u = mk(OP_ADD,  SRC_X,  SRC_H,  SRC_X,  1'b1);
        endcase
        return u;
    endfunction

    // xm*xm is kept in U and reused for k2 and k3; U later holds x+h and k4
    function automatic uop_t prog_rk4(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = mk(OP_MUL,   SRC_X,  SRC_X,  SRC_T,  1'b0);
            5'd1:    u = mk(OP_ADD,   SRC_T,  SRC_Y,  SRC_K1, 1'b0);
            5'd2:    u = mk(OP_HALF,  SRC_H,  SRC_H,  SRC_XM, 1'b0);
            5'd3:    u = mk(OP_ADD,   SRC_X,  SRC_XM, SRC_XM, 1'b0);
            5'd4:    u = mk(OP_MUL,   SRC_H,  SRC_K1, SRC_T,  1'b0);
            5'd5:    u = mk(OP_HALF,  SRC_T,  SRC_T,  SRC_T,  1'b0);
            5'd6:    u = mk(OP_ADD,   SRC_Y,  SRC_T,  SRC_T,  1'b0);
            5'd7:    u = mk(OP_MUL,   SRC_XM, SRC_XM, SRC_U,  1'b0);
            5'd8:    u = mk(OP_ADD,   SRC_U,  SRC_T,  SRC_K2, 1'b0);
            5'd9:    u = mk(OP_MUL,   SRC_H,  SRC_K2, SRC_T,  1'b0);
            5'd10:   u = mk(OP_HALF,  SRC_T,  SRC_T,  SRC_T,  1'b0);
            5'd11:   u = mk(OP_ADD,   SRC_Y,  SRC_T,  SRC_T,  1'b0);
            5'd12:   u = mk(OP_ADD,   SRC_U,  SRC_T,  SRC_K3, 1'b0);
            5'd13:   u = mk(OP_MUL,   SRC_H,  SRC_K3, SRC_T,  1'b0);
            5'd14:   u = mk(OP_ADD,   SRC_Y,  SRC_T,  SRC_T,  1'b0);
            5'd15:   u = mk(OP_ADD,   SRC_X,  SRC_H,  SRC_U,  1'b0);
            5'd16:   u = mk(OP_MUL,   SRC_U,  SRC_U,  SRC_U,  1'b0);
            5'd17:   u = mk(OP_ADD,   SRC_U,  SRC_T,  SRC_U,  1'b0);
            5'd18:   u = mk(OP_ADD,   SRC_K2, SRC_K2, SRC_S,  1'b0);
            5'd19:   u = mk(OP_ADD,   SRC_K1, SRC_S,  SRC_S,  1'b0);
            5'd20:   u = mk(OP_ADD,   SRC_K3, SRC_K3, SRC_T,  1'b0);
            5'd21:   u = mk(OP_ADD,   SRC_S,  SRC_T,  SRC_S,  1'b0);
            5'd22:   u = mk(OP_ADD,   SRC_S,  SRC_U,  SRC_S,  1'b0);
            5'd23:   u = mk(OP_SIXTH, SRC_S,  SRC_S,  SRC_S,  1'b0);
            5'd24:   u = mk(OP_MUL,   SRC_H,  SRC_S,  SRC_T,  1'b0);
            5'd25:   u = mk(OP_ADD,   SRC_Y,  SRC_T,  SRC_Y,  1'b0);
            default: u = mk(OP_ADD,   SRC_X,  SRC_H,  SRC_X,  1'b1);
        endcase
        return u;
    endfunction

    // method code 3 runs the fourth-order program
    function automatic uop_t prog(input logic [1:0] method, input logic [PC_W-1:0] pc);
        uop_t u;
        case (method)
            METH_EULER: u = prog_euler(pc);
            METH_RK2:   u = prog_rk2(pc);
            default:    u = prog_rk4(pc);
        endcase
        return u;
    endfunction

endpackage

[rtl/odestep_mul.sv]
`timescale 1ns / 1ps
module odestep_mul #(
    parameter int VALUE_WIDTH   = odestep_pkg::VALUE_WIDTH,
    parameter int FRACTION_BITS = odestep_pkg::FRACTION_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   busy,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result,
    output logic                   sat
);

    localparam int W   = VALUE_WIDTH;
    localparam int DIG = 16;
    localparam int ND  = (W + DIG - 1) / DIG;
    localparam int BW  = ND * DIG;
    localparam int PW  = W + BW;
    localparam int CW  = $clog2(ND + 2);
    localparam logic [PW:0]  RND    = {{PW{1'b0}}, 1'b1} << (FRACTION_BITS - 1);
    localparam logic [W-1:0] VMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [CW-1:0] CNT_RND = CW'(ND);
    localparam logic [CW-1:0] CNT_FIN = CW'(ND + 1);

    logic            busy_reg, busy_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]    ma_reg, ma_next;
    logic [BW-1:0]   mb_reg, mb_next;
    logic            neg_reg, neg_next;
    logic [PW-1:0]   acc_reg, acc_next;
    logic [PW:0]     q_reg, q_next;

    logic [W-1:0]     mag_a, mag_b;
    logic [W+DIG-1:0] pp;
    logic [PW:0]      lim;
    logic [W-1:0]     qv;

    assign mag_a = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;
    assign pp    = ma_reg * mb_reg[BW-1 -: DIG];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ma_next   = mag_a;
            mb_next   = BW'(mag_b);
            neg_next  = a[W-1] ^ b[W-1];
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg < CNT_RND)
            begin
                // most significant digit of b first
                acc_next = {acc_reg[PW-DIG-1:0], {DIG{1'b0}}} + PW'(pp);
                mb_next  = {mb_reg[BW-DIG-1:0], {DIG{1'b0}}};
            end
            else if (cnt_reg == CNT_RND)
            begin
                q_next = ({1'b0, acc_reg} + RND) >> FRACTION_BITS;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
    end

    // magnitude limit is one larger on the negative side
    assign lim    = neg_reg ? (PW+1)'(VMIN) : (PW+1)'(VMAX);
    assign qv     = q_reg[W-1:0];
    assign busy   = busy_reg;
    assign done   = busy_reg && (cnt_reg == CNT_FIN);
    assign sat    = q_reg > lim;
    assign result = sat ? (neg_reg ? VMIN : VMAX) : (neg_reg ? (~qv + 1'b1) : qv);

endmodule

[rtl/odestep_div6.sv]
`timescale 1ns / 1ps
module odestep_div6 #(
    parameter int VALUE_WIDTH = odestep_pkg::VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] a,
    output logic                   busy,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int W   = VALUE_WIDTH;
    localparam int NG  = (W + 7) / 8;
    localparam int PWD = NG * 8;
    localparam int CW  = $clog2(NG + 1);
    localparam logic [CW-1:0] CNT_FIN = CW'(NG);
    // 683 / 4096 slightly above 1/6, exact floor for partial values below 1536
    localparam logic [9:0]  RECIP = 10'd683;
    localparam logic [10:0] SIX   = 11'd6;

    logic           busy_reg, busy_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [PWD-1:0] num_reg, num_next;
    logic [PWD-1:0] quo_reg, quo_next;
    logic [2:0]     rem_reg, rem_next;
    logic           neg_reg, neg_next;

    logic [W-1:0]  mag;
    logic [W-1:0]  biased;
    logic [10:0]   v;
    logic [20:0]   prod;
    logic [7:0]    qd;
    logic [10:0]   rv;
    logic [W-1:0]  qv;

    assign mag    = a[W-1] ? (~a + 1'b1) : a;
    assign biased = mag + W'(3);        // round half away from zero
    assign v      = {rem_reg, num_reg[PWD-1 -: 8]};
    assign prod   = v * RECIP;
    assign qd     = prod[19:12];
    assign rv     = v - ({3'b000, qd} * SIX);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = PWD'(biased);
            quo_next  = '0;
            rem_next  = '0;
            neg_next  = a[W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg < CNT_FIN)
            begin
                cnt_next = cnt_reg + 1'b1;
                num_next = {num_reg[PWD-9:0], 8'h00};
                quo_next = {quo_reg[PWD-9:0], qd};
                rem_next = rv[2:0];
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign qv     = quo_reg[W-1:0];
    assign busy   = busy_reg;
    assign done   = busy_reg && (cnt_reg == CNT_FIN);
    assign result = neg_reg ? (~qv + 1'b1) : qv;

endmodule

[rtl/odestep_dp.sv]
`timescale 1ns / 1ps
module odestep_dp #(
    parameter int VALUE_WIDTH   = odestep_pkg::VALUE_WIDTH,
    parameter int FRACTION_BITS = odestep_pkg::FRACTION_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  odestep_pkg::dp_cmd_t   cmd,
    output odestep_pkg::dp_stat_t  stat,
    input  logic [VALUE_WIDTH-1:0] start_x,
    input  logic [VALUE_WIDTH-1:0] start_y,
    input  logic [VALUE_WIDTH-1:0] step_h,
    output logic [VALUE_WIDTH-1:0] out_x,
    output logic [VALUE_WIDTH-1:0] out_y,
    output logic                   out_sat
);

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] x_reg, y_reg;
    logic [W-1:0] k1_reg, k2_reg, k3_reg, t_reg, xm_reg, u_reg, s_reg;
    logic [W-1:0] out_x_reg, out_y_reg;
    logic         out_sat_reg;
    logic         sat_reg, sat_next;
    logic [3:0]   pend_dst_reg;

    logic [W-1:0] opa, opb;
    logic [W:0]   sum;
    logic         ovf;
    logic [W-1:0] add_res;
    logic [W-1:0] hmag, hq, half_res;
    logic [W:0]   hsum;

    logic         single_op;
    logic         mul_start, mul_busy, mul_done, mul_sat;
    logic [W-1:0] mul_res;
    logic         six_start, six_busy, six_done;
    logic [W-1:0] six_res;

    logic         wr_en;
    logic [3:0]   wr_dst;
    logic [W-1:0] wr_val;

    always_comb
    begin
        case (cmd.uop.src_a)
            odestep_pkg::SRC_X:  opa = x_reg;
            odestep_pkg::SRC_Y:  opa = y_reg;
            odestep_pkg::SRC_H:  opa = step_h;
            odestep_pkg::SRC_K1: opa = k1_reg;
            odestep_pkg::SRC_K2: opa = k2_reg;
            odestep_pkg::SRC_K3: opa = k3_reg;
            odestep_pkg::SRC_T:  opa = t_reg;
            odestep_pkg::SRC_XM: opa = xm_reg;
            odestep_pkg::SRC_U:  opa = u_reg;
            default:             opa = s_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.uop.src_b)
            odestep_pkg::SRC_X:  opb = x_reg;
            odestep_pkg::SRC_Y:  opb = y_reg;
            odestep_pkg::SRC_H:  opb = step_h;
            odestep_pkg::SRC_K1: opb = k1_reg;
            odestep_pkg::SRC_K2: opb = k2_reg;
            odestep_pkg::SRC_K3: opb = k3_reg;
            odestep_pkg::SRC_T:  opb = t_reg;
            odestep_pkg::SRC_XM: opb = xm_reg;
            odestep_pkg::SRC_U:  opb = u_reg;
            default:             opb = s_reg;
        endcase
    end

    // saturating add
    assign sum     = {opa[W-1], opa} + {opb[W-1], opb};
    assign ovf     = sum[W] ^ sum[W-1];
    assign add_res = ovf ? (sum[W] ? VMIN : VMAX) : sum[W-1:0];

    // halving, ties away from zero; cannot overflow
    assign hmag     = opa[W-1] ? (~opa + 1'b1) : opa;
    assign hsum     = {1'b0, hmag} + 1'b1;
    assign hq       = hsum[W:1];
    assign half_res = opa[W-1] ? (~hq + 1'b1) : hq;

    assign single_op = (cmd.uop.op == odestep_pkg::OP_ADD) ||
                       (cmd.uop.op == odestep_pkg::OP_HALF);
    assign mul_start = cmd.issue && (cmd.uop.op == odestep_pkg::OP_MUL);
    assign six_start = cmd.issue && (cmd.uop.op == odestep_pkg::OP_SIXTH);

    odestep_mul #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (opa),
        .b      (opb),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res),
        .sat    (mul_sat)
    );

    odestep_div6 #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div6 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (six_start),
        .a      (opa),
        .busy   (six_busy),
        .done   (six_done),
        .result (six_res)
    );

    always_comb
    begin
        wr_en  = 1'b0;
        wr_dst = cmd.uop.dst;
        wr_val = add_res;
        if (mul_done)
        begin
            wr_en  = 1'b1;
            wr_dst = pend_dst_reg;
            wr_val = mul_res;
        end
        else if (six_done)
        begin
            wr_en  = 1'b1;
            wr_dst = pend_dst_reg;
            wr_val = six_res;
        end
        else if (cmd.issue && single_op)
        begin
            wr_en  = 1'b1;
            wr_val = (cmd.uop.op == odestep_pkg::OP_HALF) ? half_res : add_res;
        end
    end

    always_comb
    begin
        sat_next = sat_reg;
        if (cmd.clear_sat)
            sat_next = 1'b0;
        else if ((mul_done && mul_sat) ||
                 (cmd.issue && (cmd.uop.op == odestep_pkg::OP_ADD) && ovf))
            sat_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            sat_reg <= sat_next;
            if (cmd.restart)
            begin
                x_reg <= start_x;
                y_reg <= start_y;
            end
            else if (wr_en && (wr_dst == odestep_pkg::SRC_X))
                x_reg <= wr_val;
            else if (wr_en && (wr_dst == odestep_pkg::SRC_Y))
                y_reg <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue && !single_op)
            pend_dst_reg <= cmd.uop.dst;
        if (wr_en)
        begin
            case (wr_dst)
                odestep_pkg::SRC_K1: k1_reg <= wr_val;
                odestep_pkg::SRC_K2: k2_reg <= wr_val;
                odestep_pkg::SRC_K3: k3_reg <= wr_val;
                odestep_pkg::SRC_T:  t_reg  <= wr_val;
                odestep_pkg::SRC_XM: xm_reg <= wr_val;
                odestep_pkg::SRC_U:  u_reg  <= wr_val;
                odestep_pkg::SRC_S:  s_reg  <= wr_val;
                default:             ;
            endcase
        end
        if (cmd.load_out)
        begin
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign stat.busy = mul_busy | six_busy;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_sat   = out_sat_reg;

`ifndef SYNTHESIS
    a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && six_busy))
        else $error("multiplier and divider busy together");

    a_no_write_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || six_done) |-> !cmd.issue)
        else $error("operation issued while a unit completes");
`endif

endmodule

[rtl/odestep_ctrl.sv]
`timescale 1ns / 1ps
module odestep_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 restart,
    input  logic [odestep_pkg::STEP_W-1:0]       step_count,
    input  logic [1:0]                           method,
    output odestep_pkg::dp_cmd_t                 cmd,
    input  odestep_pkg::dp_stat_t                stat,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [odestep_pkg::STEP_W-1:0]       out_idx,
    output logic                                 out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [odestep_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [odestep_pkg::STEP_W-1:0]   steps_reg, steps_next;
    logic                             out_valid_reg, out_valid_next;
    logic [odestep_pkg::STEP_W-1:0]   out_idx_reg, out_idx_next;
    logic                             out_last_reg, out_last_next;
    logic [odestep_pkg::STEP_W-1:0]   steps_eff;
    odestep_pkg::uop_t                uop;

    assign uop       = odestep_pkg::prog(method, pc_reg);
    assign steps_eff = restart ? '0 : steps_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        s_ready        = 1'b0;
        cmd.restart    = 1'b0;
        cmd.clear_sat  = 1'b0;
        cmd.issue      = 1'b0;
        cmd.uop        = uop;
        cmd.load_out   = 1'b0;

        if (m_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.restart   = restart;
                    cmd.clear_sat = 1'b1;
                    steps_next    = steps_eff;
                    pc_next       = '0;
                    // exhausted: no step, the word repeats the current point
                    state_next    = (steps_eff < step_count) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (!stat.busy)
                begin
                    cmd.issue = 1'b1;
                    if (uop.fin)
                    begin
                        steps_next = steps_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    out_idx_next   = steps_reg;
                    out_last_next  = steps_reg >= step_count;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid  = out_valid_reg;
    assign out_idx  = out_idx_reg;
    assign out_last = out_last_reg;

`ifndef SYNTHESIS
    a_issue_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !stat.busy)
        else $error("operation issued to a busy datapath");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("pending output word overwritten");

    a_step_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && uop.fin) |=> (steps_reg == $past(steps_reg) + 1'b1))
        else $error("finished step not counted");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (steps_reg < step_count))
        else $error("step taken past the step count");
`endif

endmodule

[rtl/ode_step_euler_rk2_rk4.sv]
`timescale 1ns / 1ps
// Fixed-point integrator for y' = x*x + y, one step per input word.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 start_x,
// 1 start_y, 2 step_size, 3 step_count, 4 method (0 Euler, 1 RK2, 2 RK4).
// Write only while the block is idle; cfg_ready is always high.
// Input word: s_axis_tdata[0] = restart, which reloads the start point and
// clears the step counter before the step. Output word: x, y and step index
// in tdata, tlast when the step count is reached, tuser = saturation flag.
// Once the step count is reached further words repeat the final point.
// One step is a microcode sequence over one shared multiplier and a
// radix-256 divide-by-six unit; no new word is taken while a step runs.
// The next word is accepted as soon as the result sits in the output
// register, even while m_axis_tready is low; a stalled output holds the
// sequencer in its final state until that register frees up.
// Reset clears x, y and the step count to zero and the registers to their
// defaults; start point is taken only on a restart word.
module ode_step_euler_rk2_rk4 #(
    parameter int VALUE_WIDTH   = odestep_pkg::VALUE_WIDTH,
    parameter int FRACTION_BITS = odestep_pkg::FRACTION_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,  // [0] restart
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // x_out, y_out, step_index, zero fill
    output logic [((2*VALUE_WIDTH+odestep_pkg::STEP_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                                   m_axis_tlast,
    output logic [0:0]                             m_axis_tuser,  // [0] saturated
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [odestep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [VALUE_WIDTH-1:0]                 cfg_data
);

    localparam int W   = VALUE_WIDTH;
    localparam int TDW = ((2*VALUE_WIDTH + odestep_pkg::STEP_W + 7) / 8) * 8;

    logic [W-1:0]                   start_x_reg, start_y_reg, step_h_reg;
    logic [odestep_pkg::STEP_W-1:0] step_count_reg;
    logic [1:0]                     method_reg;

    odestep_pkg::dp_cmd_t           cmd;
    odestep_pkg::dp_stat_t          stat;
    logic [W-1:0]                   out_x, out_y;
    logic                           out_sat;
    logic [odestep_pkg::STEP_W-1:0] out_idx;
    logic                           out_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            step_h_reg     <= '0;
            step_count_reg <= odestep_pkg::STEP_COUNT_RESET;
            method_reg     <= odestep_pkg::METH_RK4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                odestep_pkg::REG_START_X:    start_x_reg    <= cfg_data;
                odestep_pkg::REG_START_Y:    start_y_reg    <= cfg_data;
                odestep_pkg::REG_STEP_SIZE:  step_h_reg     <= cfg_data;
                odestep_pkg::REG_STEP_COUNT: step_count_reg <= cfg_data[odestep_pkg::STEP_W-1:0];
                odestep_pkg::REG_METHOD:     method_reg     <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

    odestep_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .restart    (s_axis_tdata[0]),
        .step_count (step_count_reg),
        .method     (method_reg),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .out_idx    (out_idx),
        .out_last   (out_last)
    );

    odestep_dp #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .step_h  (step_h_reg),
        .out_x   (out_x),
        .out_y   (out_y),
        .out_sat (out_sat)
    );

    assign m_axis_tdata    = TDW'({out_idx, out_y, out_x});
    assign m_axis_tlast    = out_last;
    assign m_axis_tuser[0] = out_sat;

endmodule
